### design/pwlc_pkg.sv
// Shared types and constants for the piecewise linear curve table.
// Holds the item structs, node layout, status codes and sequencer states.
// No dependencies; used by pwlc_div and piecewise_linear_curve_table_core.
`default_nettype none

package pwlc_pkg;

   // Width of one Q1.16 value, where 65536 stands for 1.0.
   localparam int VAL_W = 17;
   // Width of the interpolation product (up to 65536 * 65536).
   localparam int PROD_W = 2 * VAL_W - 1;
   // Number of quotient bits produced by the serial divider.
   localparam int DIV_STEPS = VAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [VAL_W-1:0] Q_ONE  = VAL_W'(65536);
   localparam logic [VAL_W-1:0] Q_ZERO = '0;

   typedef enum logic {
      KIND_ADD    = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_ZERO = 2'd1,
      STATUS_NO_ONE  = 2'd2,
      STATUS_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type         kind;
      logic [VAL_W-1:0] x_pos;
      logic [VAL_W-1:0] y_level;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] curve_value;
      status_type       status;
   } rsp_type;

   // One curve node as held in the node memory.
   typedef struct packed {
      logic [VAL_W-1:0] x;
      logic [VAL_W-1:0] y;
   } node_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LO_RD,
      ST_LO_CHK,
      ST_HI_RD,
      ST_HI_CHK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_INSERT,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_DIFF,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   // Limits a 17-bit operand to 1.0.
   function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
      sat_one = (v > Q_ONE) ? Q_ONE : v;
   endfunction

endpackage

`default_nettype wire

### design/pwlc_div.sv
// Restoring serial divider for the curve table, one quotient bit per cycle.
// Depends on pwlc_pkg; the caller guarantees the quotient fits in VAL_W bits.
// Instantiated by piecewise_linear_curve_table_core.
`default_nettype none

module pwlc_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [pwlc_pkg::PROD_W-1:0]  dividend,
   input  wire logic [pwlc_pkg::VAL_W-1:0]   divisor,
   output logic                              done,
   output logic [pwlc_pkg::VAL_W-1:0]        quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [pwlc_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [pwlc_pkg::VAL_W-1:0]        rem_ff, rem_in;
   logic [pwlc_pkg::VAL_W-1:0]        low_ff, low_in;
   logic [pwlc_pkg::VAL_W-1:0]        divisor_ff, divisor_in;
   logic [pwlc_pkg::VAL_W:0]          trial;
   logic [pwlc_pkg::VAL_W:0]          trial_diff;
   logic                              trial_ge;

   // Shift the next dividend bit into the remainder and try the subtraction.
   assign trial      = {rem_ff, low_ff[pwlc_pkg::VAL_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});

   // Step control: load on start, then one quotient bit a cycle.
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      low_in     = low_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = pwlc_pkg::DIV_CNT_W'(pwlc_pkg::DIV_STEPS);
         rem_in     = pwlc_pkg::VAL_W'(dividend[pwlc_pkg::PROD_W-1:pwlc_pkg::VAL_W]);
         low_in     = dividend[pwlc_pkg::VAL_W-1:0];
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_diff[pwlc_pkg::VAL_W-1:0] : trial[pwlc_pkg::VAL_W-1:0];
         low_in = {low_ff[pwlc_pkg::VAL_W-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pwlc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = low_ff;

endmodule

`default_nettype wire

### design/piecewise_linear_curve_table_core.sv
// Top level of the piecewise linear curve table: node memory, sequencer and
// interpolation datapath. Depends on pwlc_pkg and instantiates pwlc_div.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  req_item (pwlc_pkg::req_type)
//   rsp      out  rsp_valid/rsp_stall  rsp_item (pwlc_pkg::rsp_type)
//
// One item is handled at a time; req_stall is low only while the sequencer idles.
// The node memory has one read and one write port, so each node walked takes a
// read state and a check state, and each node moved takes a read and a write state.
// An interpolating lookup then multiplies and waits on the serial divider.
// Reset empties the table at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken.
`default_nettype none

module piecewise_linear_curve_table_core #(
   parameter int MAX_NODES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pwlc_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pwlc_pkg::rsp_type      rsp_item
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int VW    = pwlc_pkg::VAL_W;

   pwlc_pkg::state_type        state_ff, state_in;
   pwlc_pkg::kind_type         kind_ff, kind_in;
   logic [VW-1:0]              xq_ff, xq_in;
   logic [VW-1:0]              yv_ff, yv_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [CNT_W-1:0]           j_ff, j_in;
   pwlc_pkg::node_type         prev_ff, prev_in;
   pwlc_pkg::node_type         cur_ff, cur_in;
   logic [VW-1:0]              dxq_ff, dxq_in;
   logic [VW-1:0]              dmag_ff, dmag_in;
   logic [VW-1:0]              dx_ff, dx_in;
   logic                       neg_ff, neg_in;
   logic [pwlc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [VW-1:0]              value_ff, value_in;
   pwlc_pkg::status_type       status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pwlc_pkg::rsp_type          rsp_item_ff, rsp_item_in;

   pwlc_pkg::node_type         node_mem_ff [MAX_NODES];
   pwlc_pkg::node_type         rd_data_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic [IDX_W-1:0]           wr_addr;
   pwlc_pkg::node_type         wr_data;
   logic                       mem_we;

   logic                       req_fire;
   logic                       rsp_free;
   logic                       div_start;
   logic                       div_done;
   logic [VW-1:0]              div_quot;
   logic [2*VW-1:0]            prod_full;
   logic signed [VW+1:0]       q_signed;
   logic signed [VW+1:0]       interp_sum;
   logic [CNT_W-1:0]           count_m1;
   logic [CNT_W-1:0]           j_m1;

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != pwlc_pkg::ST_IDLE);
   assign count_m1 = count_ff - 1'b1;
   assign j_m1     = j_ff - 1'b1;

   // Node memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         node_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= node_mem_ff[rd_addr];
   end

   // Serial divider for the interpolation quotient.
   pwlc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (dx_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Interpolated value y0 +/- quotient, held within [0, 1.0].
   assign prod_full  = dxq_ff * dmag_ff;
   assign q_signed   = $signed({2'b00, div_quot});
   assign interp_sum = $signed({2'b00, prev_ff.y}) + (neg_ff ? -q_signed : q_signed);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pwlc_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_item.kind == pwlc_pkg::KIND_LOOKUP) ?
                          pwlc_pkg::ST_LO_RD : pwlc_pkg::ST_SCAN_RD;
            end
         end
         pwlc_pkg::ST_LO_RD: begin
            state_in = (count_ff == '0) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_LO_CHK;
         end
         pwlc_pkg::ST_LO_CHK: begin
            state_in = (rd_data_ff.x != pwlc_pkg::Q_ZERO) ?
                       pwlc_pkg::ST_DONE : pwlc_pkg::ST_HI_RD;
         end
         pwlc_pkg::ST_HI_RD: begin
            state_in = pwlc_pkg::ST_HI_CHK;
         end
         pwlc_pkg::ST_HI_CHK: begin
            state_in = (rd_data_ff.x != pwlc_pkg::Q_ONE) ?
                       pwlc_pkg::ST_DONE : pwlc_pkg::ST_SCAN_RD;
         end
         pwlc_pkg::ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = (kind_ff == pwlc_pkg::KIND_ADD) ?
                          pwlc_pkg::ST_INSERT : pwlc_pkg::ST_DONE;
            end else begin
               state_in = pwlc_pkg::ST_SCAN_CHK;
            end
         end
         pwlc_pkg::ST_SCAN_CHK: begin
            if (rd_data_ff.x >= xq_ff) begin
               if (kind_ff == pwlc_pkg::KIND_ADD) begin
                  state_in = (rd_data_ff.x == xq_ff) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_INSERT;
               end else begin
                  state_in = (idx_ff == '0) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_DIFF;
               end
            end else begin
               state_in = pwlc_pkg::ST_SCAN_RD;
            end
         end
         pwlc_pkg::ST_INSERT: begin
            state_in = (count_ff == CNT_W'(MAX_NODES)) ?
                       pwlc_pkg::ST_DONE : pwlc_pkg::ST_SHIFT_RD;
         end
         pwlc_pkg::ST_SHIFT_RD: begin
            state_in = (j_ff == idx_ff) ? pwlc_pkg::ST_DONE : pwlc_pkg::ST_SHIFT_WR;
         end
         pwlc_pkg::ST_SHIFT_WR: begin
            state_in = pwlc_pkg::ST_SHIFT_RD;
         end
         pwlc_pkg::ST_DIFF: begin
            state_in = pwlc_pkg::ST_MUL;
         end
         pwlc_pkg::ST_MUL: begin
            state_in = pwlc_pkg::ST_DIV_GO;
         end
         pwlc_pkg::ST_DIV_GO: begin
            state_in = pwlc_pkg::ST_DIV_WAIT;
         end
         pwlc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = pwlc_pkg::ST_DONE;
            end
         end
         pwlc_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = pwlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pwlc_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls for each sequencer state.
   always_comb begin
      kind_in   = kind_ff;
      xq_in     = xq_ff;
      yv_in     = yv_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      j_in      = j_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      dxq_in    = dxq_ff;
      dmag_in   = dmag_ff;
      dx_in     = dx_ff;
      neg_in    = neg_ff;
      prod_in   = prod_ff;
      value_in  = value_ff;
      status_in = status_ff;
      rd_addr   = '0;
      wr_addr   = idx_ff[IDX_W-1:0];
      wr_data   = rd_data_ff;
      mem_we    = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         pwlc_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in   = req_item.kind;
               xq_in     = pwlc_pkg::sat_one(req_item.x_pos);
               yv_in     = pwlc_pkg::sat_one(req_item.y_level);
               idx_in    = '0;
               value_in  = '0;
               status_in = pwlc_pkg::STATUS_OK;
            end
         end
         pwlc_pkg::ST_LO_RD: begin
            rd_addr = '0;
            if (count_ff == '0) begin
               status_in = pwlc_pkg::STATUS_NO_ZERO;
            end
         end
         pwlc_pkg::ST_LO_CHK: begin
            if (rd_data_ff.x != pwlc_pkg::Q_ZERO) begin
               status_in = pwlc_pkg::STATUS_NO_ZERO;
            end
         end
         pwlc_pkg::ST_HI_RD: begin
            // The node at 1.0, if present, is always the last one.
            rd_addr = count_m1[IDX_W-1:0];
         end
         pwlc_pkg::ST_HI_CHK: begin
            if (rd_data_ff.x != pwlc_pkg::Q_ONE) begin
               status_in = pwlc_pkg::STATUS_NO_ONE;
            end
         end
         pwlc_pkg::ST_SCAN_RD: begin
            rd_addr = idx_ff[IDX_W-1:0];
         end
         pwlc_pkg::ST_SCAN_CHK: begin
            if (rd_data_ff.x >= xq_ff) begin
               cur_in = rd_data_ff;
               if (kind_ff == pwlc_pkg::KIND_LOOKUP && idx_ff == '0) begin
                  value_in = rd_data_ff.y;
               end
            end else begin
               // Keep the node below the query as the left end of the segment.
               prev_in = rd_data_ff;
               idx_in  = idx_ff + 1'b1;
            end
         end
         pwlc_pkg::ST_INSERT: begin
            j_in = count_ff;
            if (count_ff == CNT_W'(MAX_NODES)) begin
               status_in = pwlc_pkg::STATUS_FULL;
            end
         end
         pwlc_pkg::ST_SHIFT_RD: begin
            if (j_ff == idx_ff) begin
               mem_we   = 1'b1;
               wr_addr  = idx_ff[IDX_W-1:0];
               wr_data  = '{x: xq_ff, y: yv_ff};
               count_in = count_ff + 1'b1;
            end else begin
               rd_addr = j_m1[IDX_W-1:0];
            end
         end
         pwlc_pkg::ST_SHIFT_WR: begin
            // Move one node up by a place to open the insertion slot.
            mem_we  = 1'b1;
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = rd_data_ff;
            j_in    = j_m1;
         end
         pwlc_pkg::ST_DIFF: begin
            dxq_in = xq_ff - prev_ff.x;
            dx_in  = cur_ff.x - prev_ff.x;
            if (cur_ff.y >= prev_ff.y) begin
               dmag_in = cur_ff.y - prev_ff.y;
               neg_in  = 1'b0;
            end else begin
               dmag_in = prev_ff.y - cur_ff.y;
               neg_in  = 1'b1;
            end
         end
         pwlc_pkg::ST_MUL: begin
            prod_in = prod_full[pwlc_pkg::PROD_W-1:0];
         end
         pwlc_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
         end
         pwlc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (interp_sum < 0) begin
                  value_in = '0;
               end else if (interp_sum > $signed({2'b00, pwlc_pkg::Q_ONE})) begin
                  value_in = pwlc_pkg::Q_ONE;
               end else begin
                  value_in = interp_sum[VW-1:0];
               end
            end
         end
         pwlc_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Output register: load the finished item once the slot is free.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (state_ff == pwlc_pkg::ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = '{curve_value: value_ff, status: status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwlc_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      xq_ff       <= xq_in;
      yv_ff       <= yv_in;
      idx_ff      <= idx_in;
      j_ff        <= j_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      dxq_ff      <= dxq_in;
      dmag_ff     <= dmag_in;
      dx_ff       <= dx_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The node count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_NODES))
      else $error("node count above table size");

   // Memory writes stay inside the filled part of the table plus the new slot.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CNT_W'(wr_addr) <= count_ff))
      else $error("node write beyond fill level");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == pwlc_pkg::ST_DIV_WAIT))
      else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
